>>> rtl/stereo_bus_saturator_top_macros.svh
// Assertion macros used by the stereo bus saturator top level.
`ifndef STEREO_BUS_SATURATOR_TOP_MACROS_SVH
`define STEREO_BUS_SATURATOR_TOP_MACROS_SVH

// The consequence must hold in the same cycle as the antecedent.
`define SBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbs assertion failed (same cycle)");

// The consequence must hold in the cycle after the antecedent.
`define SBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbs assertion failed (next cycle)");

`endif

>>> rtl/sbs_pkg.sv
// Shared types, constants and elaboration-time table functions of the bus saturator.
package sbs_pkg;

    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int SHAPER_DEPTH_DEF = 1024;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PRE_B0       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_A1       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_A2       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_B0      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_A1      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_A2      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GAIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 3'd7;

    localparam logic [17:0] TARGET_GAIN_RST  = 18'd67502;
    localparam logic [12:0] BLOCK_LENGTH_RST = 13'd256;

    localparam logic [31:0] RATE_FLOOR = 32'h0040_0000;
    localparam logic [31:0] DECAY_MUL  = 32'd4294537799;
    localparam logic [31:0] DECAY_SUB  = 32'd655;
    localparam logic [63:0] W_GOLD     = 64'd2654435769;
    localparam logic [63:0] W_REST     = 64'd1640531527;

    localparam logic [31:0] ATAN_Q30 [11] = '{
        32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576
    };

    typedef struct packed {
        logic signed [31:0] b0;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
    } t_biquad_coef;

    typedef struct packed {
        logic        start;
        logic        first;
        logic [17:0] target;
        logic [12:0] block_len;
    } t_gain_ctl;

    typedef struct packed {
        logic        done;
        logic [29:0] trim;
    } t_gain_sts;

    typedef struct packed {
        logic        start;
        logic [29:0] trim;
    } t_lane_ctl;

    // Round half up, then arithmetic shift right.
    function automatic logic signed [63:0] sbs_rshr(input logic signed [63:0] v,
                                                    input int unsigned s);
        logic signed [63:0] bias;
        if (s == 0) begin
            return v;
        end
        bias = 64'sd1 <<< (s - 1);
        return (v + bias) >>> s;
    endfunction

    function automatic logic signed [31:0] sbs_sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] sbs_isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] bv;
        r   = '0;
        rem = v;
        for (int i = 0; i < 32; i++) begin
            bv = 64'd1 << (62 - 2 * i);
            if (rem >= r + bv) begin
                rem = rem - (r + bv);
                r   = (r >> 1) + bv;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] sbs_udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Arcsine of a Q.30 value in [0, 1] by CORDIC vectoring.
    function automatic logic [63:0] sbs_asin(input logic [63:0] u);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] step;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [63:0]        uu;
        if (u == 64'd0) begin
            return 64'd0;
        end
        uu = (u > (64'd1 << 30)) ? (64'd1 << 30) : u;
        x  = $signed(sbs_isqrt((64'd1 << 60) - uu * uu));
        y  = $signed(uu);
        z  = '0;
        for (int i = 0; i < 30; i++) begin
            step = (i < 11) ? $signed({32'd0, ATAN_Q30[i]}) : (64'sd1 <<< (30 - i));
            dx   = y >>> i;
            dy   = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + step;
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - step;
            end
        end
        return (z > 0) ? $unsigned(z) : 64'd0;
    endfunction

    // Saturator curve at a Q.30 point, result Q.30.
    function automatic logic [31:0] sbs_shaper_point(input logic [63:0] u);
        logic [63:0] a1;
        logic [63:0] a2;
        logic [63:0] q;
        logic [63:0] f;
        if (u == 64'd0) begin
            return 32'd0;
        end
        a1 = sbs_asin((u * u + (64'd1 << 29)) >> 30);
        a2 = sbs_asin(u);
        q  = sbs_udiv((a1 << 30) + (u >> 1), u);
        if (q > 64'h7FFF_FFFF) begin
            q = 64'h7FFF_FFFF;
        end
        if (a2 > 64'h7FFF_FFFF) begin
            a2 = 64'h7FFF_FFFF;
        end
        f = (q * W_GOLD + a2 * W_REST + (64'd1 << 31)) >> 32;
        return f[31:0];
    endfunction

    function automatic logic [31:0] sbs_rom_value(input int k, input int depth);
        logic [63:0] u;
        u = sbs_udiv(64'(k) << 30, 64'(depth));
        return sbs_shaper_point(u);
    endfunction

endpackage

>>> rtl/sbs_in_if.sv
// Input channel interface: one stereo pair and its block mark per beat.
interface sbs_in_if
    import sbs_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          first_of_block;

    modport source (output valid, output left_in, output right_in, output first_of_block,
                    input ready);
    modport sink (input valid, input left_in, input right_in, input first_of_block,
                  output ready);
endinterface

>>> rtl/sbs_out_if.sv
// Output channel interface: one processed stereo pair per beat.
interface sbs_out_if
    import sbs_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

>>> rtl/sbs_gain.sv
// Shared gain unit: chase rate, smoothed gain by bit-serial division, trim by bit-serial root.
module sbs_gain
    import sbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_gain_ctl i_ctl,
    output t_gain_sts o_sts
);
    localparam logic [2:0] G_IDLE  = 3'd0;
    localparam logic [2:0] G_DECAY = 3'd1;
    localparam logic [2:0] G_SUB   = 3'd2;
    localparam logic [2:0] G_GMUL  = 3'd3;
    localparam logic [2:0] G_NUM   = 3'd4;
    localparam logic [2:0] G_DIV   = 3'd5;
    localparam logic [2:0] G_SQRT  = 3'd6;
    localparam logic [2:0] G_DONE  = 3'd7;

    logic [2:0]  r_state, n_state;
    logic [31:0] r_rate, n_rate;
    logic [31:0] r_g, n_g;
    logic        r_primed, n_primed;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_prod, n_prod;
    logic [32:0] r_den, n_den;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_q, n_q;
    logic [59:0] r_rad, n_rad;
    logic [29:0] r_root, n_root;
    logic [31:0] r_srem, n_srem;
    logic [29:0] r_trim, n_trim;

    logic [31:0] w_tq;
    logic [31:0] w_cap;
    logic [31:0] w_start_rate;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [31:0] w_decayed;
    logic [32:0] w_den;
    logic [63:0] w_num;
    logic [33:0] w_div_t;
    logic        w_div_bit;
    logic [31:0] w_q_next;
    logic [32:0] w_sq_t;
    logic [32:0] w_sq_trial;
    logic        w_sq_bit;
    logic [29:0] w_root_next;

    assign w_tq  = {2'b00, i_ctl.target, 12'd0};
    assign w_cap = {3'b000, i_ctl.block_len, 16'd0};

    // Block start: double the rate while the gain still moves, then cap it.
    always_comb begin
        w_start_rate = r_rate;
        if (i_ctl.first || !r_primed) begin
            if (!r_primed || (r_g != w_tq)) begin
                w_start_rate = r_rate[31] ? 32'hFFFF_FFFF : {r_rate[30:0], 1'b0};
            end
            if (w_start_rate > w_cap) begin
                w_start_rate = w_cap;
            end
        end
    end

    assign w_mul_a   = (r_state == G_GMUL) ? r_g : r_rate;
    assign w_mul_b   = (r_state == G_GMUL) ? r_rate : DECAY_MUL;
    assign w_decayed = r_prod[63:32];

    assign w_den = {1'b0, r_rate} + 33'd65536;
    assign w_num = r_prod + {16'd0, w_tq, 16'd0} + {32'd0, w_den[32:1]};

    assign w_div_t   = {r_rem, r_q[31]};
    assign w_div_bit = (w_div_t >= {1'b0, r_den});
    assign w_q_next  = {r_q[30:0], w_div_bit};

    assign w_sq_t      = {r_srem[30:0], r_rad[59:58]};
    assign w_sq_trial  = {1'b0, r_root, 2'b01};
    assign w_sq_bit    = (w_sq_t >= w_sq_trial);
    assign w_root_next = {r_root[28:0], w_sq_bit};

    always_comb begin
        n_state  = r_state;
        n_rate   = r_rate;
        n_g      = r_g;
        n_primed = r_primed;
        n_cnt    = r_cnt;
        n_prod   = {32'd0, w_mul_a} * {32'd0, w_mul_b};
        n_den    = r_den;
        n_rem    = r_rem;
        n_q      = r_q;
        n_rad    = r_rad;
        n_root   = r_root;
        n_srem   = r_srem;
        n_trim   = r_trim;
        unique case (r_state)
            G_IDLE: begin
                if (i_ctl.start) begin
                    n_rate = w_start_rate;
                    if (!r_primed) begin
                        n_g      = w_tq;
                        n_primed = 1'b1;
                    end
                    n_state = G_DECAY;
                end
            end
            G_DECAY: begin
                n_state = G_SUB;
            end
            G_SUB: begin
                if (w_decayed < RATE_FLOOR + DECAY_SUB) begin
                    n_rate = RATE_FLOOR;
                end else begin
                    n_rate = w_decayed - DECAY_SUB;
                end
                n_state = G_GMUL;
            end
            G_GMUL: begin
                n_state = G_NUM;
            end
            G_NUM: begin
                // The quotient fits 32 bits, so the upper half is already below the divisor.
                n_den   = w_den;
                n_rem   = {1'b0, w_num[63:32]};
                n_q     = w_num[31:0];
                n_cnt   = '0;
                n_state = G_DIV;
            end
            G_DIV: begin
                n_rem = w_div_bit ? 33'(w_div_t - {1'b0, r_den}) : w_div_t[32:0];
                n_q   = w_q_next;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_g     = w_q_next;
                    n_rad   = {w_q_next[31:0], 28'd0};
                    n_root  = '0;
                    n_srem  = '0;
                    n_cnt   = '0;
                    n_state = G_SQRT;
                end
            end
            G_SQRT: begin
                n_srem = w_sq_bit ? 32'(w_sq_t - w_sq_trial) : w_sq_t[31:0];
                n_root = w_root_next;
                n_rad  = {r_rad[57:0], 2'b00};
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt == 5'd29) begin
                    n_trim  = w_root_next;
                    n_state = G_DONE;
                end
            end
            G_DONE: begin
                n_state = G_IDLE;
            end
            default: begin
                n_state = G_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= G_IDLE;
            r_rate   <= RATE_FLOOR;
            r_g      <= '0;
            r_primed <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_rate   <= n_rate;
            r_g      <= n_g;
            r_primed <= n_primed;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_rad  <= n_rad;
        r_root <= n_root;
        r_srem <= n_srem;
        r_trim <= n_trim;
    end

    assign o_sts.done = (r_state == G_DONE);
    assign o_sts.trim = r_trim;
endmodule

>>> rtl/sbs_lane.sv
// One channel lane: pre biquad, trim, table saturator, post biquad and re-gain on one multiplier.
module sbs_lane
    import sbs_pkg::*;
#(
    parameter int SAMPLE_BITS        = SAMPLE_BITS_DEF,
    parameter int SHAPER_TABLE_DEPTH = SHAPER_DEPTH_DEF
)(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_ctl                     i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  t_biquad_coef                  i_pre,
    input  t_biquad_coef                  i_post,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);
    localparam int ROM_N = SHAPER_TABLE_DEPTH + 1;
    localparam int AW    = $clog2(ROM_N);

    localparam int unsigned IN_SH_L  = (SAMPLE_BITS - 1 <= 28) ? 28 - (SAMPLE_BITS - 1) : 0;
    localparam int unsigned IN_SH_R  = (SAMPLE_BITS - 1 <= 28) ? 0 : (SAMPLE_BITS - 1) - 28;
    localparam int unsigned OUT_SH_L = (SAMPLE_BITS - 3 <= 28) ? 0 : 1;
    localparam int unsigned OUT_SH_R = (SAMPLE_BITS - 3 <= 28) ? 28 - (SAMPLE_BITS - 3) : 0;

    localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));
    localparam logic signed [31:0] ONE_Q28 = 32'sd268435456;

    localparam logic [3:0] L_IDLE   = 4'd0;
    localparam logic [3:0] L_BQ     = 4'd1;
    localparam logic [3:0] L_BQ_END = 4'd2;
    localparam logic [3:0] L_TRIM   = 4'd3;
    localparam logic [3:0] L_RD0    = 4'd4;
    localparam logic [3:0] L_RD1    = 4'd5;
    localparam logic [3:0] L_INTERP = 4'd6;
    localparam logic [3:0] L_SHAPE  = 4'd7;
    localparam logic [3:0] L_REGAIN = 4'd8;
    localparam logic [3:0] L_DONE   = 4'd9;

    logic [31:0] rom [ROM_N];

    for (genvar k = 0; k < ROM_N; k++) begin : g_rom
        localparam logic [31:0] ROM_VAL = sbs_rom_value(k, SHAPER_TABLE_DEPTH);
        assign rom[k] = ROM_VAL;
    end

    logic [3:0]                    r_state;
    logic [2:0]                    r_cnt;
    logic                          r_post;
    logic signed [31:0]            r_x;
    logic signed [39:0]            r_acc;
    logic signed [63:0]            r_prod;
    logic signed [31:0]            r_pre_h [4];
    logic signed [31:0]            r_post_h [4];
    logic [AW-1:0]                 r_addr;
    logic [AW-1:0]                 r_addr1;
    logic [31:0]                   r_rd;
    logic [31:0]                   r_f0;
    logic [27:0]                   r_fr;
    logic                          r_neg;
    logic signed [SAMPLE_BITS-1:0] r_out;

    t_biquad_coef       w_coef;
    logic signed [31:0] w_h [4];
    logic signed [31:0] w_ma;
    logic signed [31:0] w_mb;
    logic signed [31:0] w_trim;
    logic signed [31:0] w_xin;
    logic signed [39:0] w_term;
    logic signed [31:0] w_y;
    logic signed [31:0] w_t;
    logic signed [31:0] w_tc;
    logic [28:0]        w_mag;
    logic [63:0]        w_p;
    logic [AW-1:0]      w_k;
    logic signed [63:0] w_shape;
    logic signed [31:0] w_xpost;
    logic signed [31:0] w_reg;
    logic signed [63:0] w_yo;

    assign w_coef = r_post ? i_post : i_pre;
    assign w_trim = $signed({2'b00, i_ctl.trim});

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_h[i] = r_post ? r_post_h[i] : r_pre_h[i];
        end
    end

    assign w_xin  = sbs_sat32(sbs_rshr(64'(i_sample) <<< IN_SH_L, IN_SH_R));
    assign w_term = 40'(sbs_rshr(r_prod, 30));
    assign w_y    = sbs_sat32(64'(r_acc));

    // Trim product back to Q4.28, clamped to +-1 ahead of the table.
    assign w_t   = sbs_sat32(sbs_rshr(r_prod, 28));
    assign w_tc  = (w_t > ONE_Q28) ? ONE_Q28 : ((w_t < -ONE_Q28) ? -ONE_Q28 : w_t);
    assign w_mag = w_tc[31] ? 29'(-w_tc) : w_tc[28:0];
    assign w_p   = {35'd0, w_mag} * 64'(SHAPER_TABLE_DEPTH);
    assign w_k   = AW'(w_p >> 28);

    always_comb begin
        w_shape = sbs_rshr($signed({32'd0, r_f0}) + sbs_rshr(r_prod, 28), 2);
        if (r_neg) begin
            w_shape = -w_shape;
        end
    end
    assign w_xpost = sbs_sat32(w_shape);

    always_comb begin
        w_reg = sbs_sat32(sbs_rshr(r_prod, 28));
        w_yo  = sbs_rshr(64'(w_reg) <<< OUT_SH_L, OUT_SH_R);
        if (w_yo > OUT_MAX) begin
            w_yo = OUT_MAX;
        end
        if (w_yo < OUT_MIN) begin
            w_yo = OUT_MIN;
        end
    end

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            L_BQ: begin
                case (r_cnt)
                    3'd0: begin
                        w_ma = w_coef.b0;
                        w_mb = r_x;
                    end
                    3'd1: begin
                        w_ma = w_coef.b0;
                        w_mb = w_h[0];
                    end
                    3'd2: begin
                        w_ma = w_coef.b0;
                        w_mb = w_h[1];
                    end
                    3'd3: begin
                        w_ma = w_coef.a1;
                        w_mb = w_h[2];
                    end
                    3'd4: begin
                        w_ma = w_coef.a2;
                        w_mb = w_h[3];
                    end
                    default: begin
                        w_ma = '0;
                        w_mb = '0;
                    end
                endcase
            end
            L_BQ_END: begin
                w_ma = w_y;
                w_mb = w_trim;
            end
            L_INTERP: begin
                w_ma = $signed(r_rd - r_f0);
                w_mb = $signed({4'd0, r_fr});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        r_rd   <= rom[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_cnt   <= '0;
            r_post  <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_pre_h[i]  <= '0;
                r_post_h[i] <= '0;
            end
        end else begin
            unique case (r_state)
                L_IDLE: begin
                    if (i_ctl.start) begin
                        r_x     <= w_xin;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_post  <= 1'b0;
                        r_state <= L_BQ;
                    end
                end
                L_BQ: begin
                    // Each product is accumulated the cycle after it is formed.
                    r_cnt <= r_cnt + 3'd1;
                    case (r_cnt)
                        3'd1, 3'd3: r_acc <= r_acc + w_term;
                        3'd2:       r_acc <= r_acc + (w_term <<< 1);
                        3'd4, 3'd5: r_acc <= r_acc - w_term;
                        default:    r_acc <= r_acc;
                    endcase
                    if (r_cnt == 3'd5) begin
                        r_state <= L_BQ_END;
                    end
                end
                L_BQ_END: begin
                    if (r_post) begin
                        r_post_h[1] <= r_post_h[0];
                        r_post_h[0] <= r_x;
                        r_post_h[3] <= r_post_h[2];
                        r_post_h[2] <= w_y;
                        r_state     <= L_REGAIN;
                    end else begin
                        r_pre_h[1] <= r_pre_h[0];
                        r_pre_h[0] <= r_x;
                        r_pre_h[3] <= r_pre_h[2];
                        r_pre_h[2] <= w_y;
                        r_state    <= L_TRIM;
                    end
                end
                L_TRIM: begin
                    r_addr  <= w_k;
                    r_addr1 <= (w_k == AW'(SHAPER_TABLE_DEPTH)) ? w_k : w_k + AW'(1);
                    r_fr    <= w_p[27:0];
                    r_neg   <= w_tc[31];
                    r_state <= L_RD0;
                end
                L_RD0: begin
                    r_addr  <= r_addr1;
                    r_state <= L_RD1;
                end
                L_RD1: begin
                    r_f0    <= r_rd;
                    r_state <= L_INTERP;
                end
                L_INTERP: begin
                    r_state <= L_SHAPE;
                end
                L_SHAPE: begin
                    r_x     <= w_xpost;
                    r_acc   <= '0;
                    r_cnt   <= '0;
                    r_post  <= 1'b1;
                    r_state <= L_BQ;
                end
                L_REGAIN: begin
                    r_out   <= w_yo[SAMPLE_BITS-1:0];
                    r_state <= L_DONE;
                end
                L_DONE: begin
                    r_state <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_done   = (r_state == L_DONE);
    assign o_sample = r_out;
endmodule

>>> rtl/stereo_bus_saturator_top.sv
// Top level of the stereo bus saturator: configuration, sequencing and output merge.
//
//   channel   dir  beat contents
//   i_in_ch   in   left_in, right_in, first_of_block
//   o_out_ch  out  left_out, right_out
//   i_cfg_*   in   register index and write data, no handshake
//
// A result passes through the shared gain unit (setup states DECAY, SUB, GMUL and NUM, the
// bit-serial divider, the bit-serial square root and a done state), then the two lanes side
// by side, each running on one sequenced 32x32 multiplier, and then the output register.
// One item is in work at a time; the next is taken as soon as the result sits in the
// output register, even while that beat is stalled downstream.
// Reset is synchronous and active low.
`include "stereo_bus_saturator_top_macros.svh"

module stereo_bus_saturator_top
    import sbs_pkg::*;
#(
    parameter int SAMPLE_BITS        = SAMPLE_BITS_DEF,
    parameter int SHAPER_TABLE_DEPTH = SHAPER_DEPTH_DEF
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sbs_in_if.sink                i_in_ch,
    sbs_out_if.source             o_out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_GAIN = 2'd1;
    localparam logic [1:0] T_LANE = 2'd2;
    localparam logic [1:0] T_OUT  = 2'd3;

    t_biquad_coef r_pre;
    t_biquad_coef r_post;
    logic [17:0]  r_target;
    logic [12:0]  r_block_len;

    logic [1:0]                    r_state;
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_right;
    logic                          r_first;
    logic                          r_done_l;
    logic                          r_done_r;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_l;
    logic signed [SAMPLE_BITS-1:0] r_out_r;

    logic                          w_in_acc;
    logic                          w_load_out;
    t_gain_ctl                     w_gain_ctl;
    t_gain_sts                     w_gain_sts;
    t_lane_ctl                     w_lane_ctl;
    logic                          w_done_l;
    logic                          w_done_r;
    logic signed [SAMPLE_BITS-1:0] w_lane_l;
    logic signed [SAMPLE_BITS-1:0] w_lane_r;

    assign i_in_ch.ready = (r_state == T_IDLE);
    assign w_in_acc      = i_in_ch.valid && i_in_ch.ready;
    assign w_load_out    = (r_state == T_OUT) && (!r_out_valid || o_out_ch.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre       <= '0;
            r_post      <= '0;
            r_target    <= TARGET_GAIN_RST;
            r_block_len <= BLOCK_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRE_B0:       r_pre.b0    <= $signed(i_cfg_data);
                CFG_PRE_A1:       r_pre.a1    <= $signed(i_cfg_data);
                CFG_PRE_A2:       r_pre.a2    <= $signed(i_cfg_data);
                CFG_POST_B0:      r_post.b0   <= $signed(i_cfg_data);
                CFG_POST_A1:      r_post.a1   <= $signed(i_cfg_data);
                CFG_POST_A2:      r_post.a2   <= $signed(i_cfg_data);
                CFG_TARGET_GAIN:  r_target    <= i_cfg_data[17:0];
                CFG_BLOCK_LENGTH: r_block_len <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    assign w_gain_ctl.start     = w_in_acc;
    assign w_gain_ctl.first     = i_in_ch.first_of_block;
    assign w_gain_ctl.target    = r_target;
    assign w_gain_ctl.block_len = r_block_len;

    sbs_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_gain_ctl),
        .o_sts   (w_gain_sts)
    );

    assign w_lane_ctl.start = w_gain_sts.done;
    assign w_lane_ctl.trim  = w_gain_sts.trim;

    sbs_lane #(
        .SAMPLE_BITS        (SAMPLE_BITS),
        .SHAPER_TABLE_DEPTH (SHAPER_TABLE_DEPTH)
    ) u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_lane_ctl),
        .i_sample (r_left),
        .i_pre    (r_pre),
        .i_post   (r_post),
        .o_done   (w_done_l),
        .o_sample (w_lane_l)
    );

    sbs_lane #(
        .SAMPLE_BITS        (SAMPLE_BITS),
        .SHAPER_TABLE_DEPTH (SHAPER_TABLE_DEPTH)
    ) u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_lane_ctl),
        .i_sample (r_right),
        .i_pre    (r_pre),
        .i_post   (r_post),
        .o_done   (w_done_r),
        .o_sample (w_lane_r)
    );

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_left  <= i_in_ch.left_in;
            r_right <= i_in_ch.right_in;
            r_first <= i_in_ch.first_of_block;
        end
        if (w_load_out) begin
            r_out_l <= w_lane_l;
            r_out_r <= w_lane_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_done_l    <= 1'b0;
            r_done_r    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                T_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= T_GAIN;
                    end
                end
                T_GAIN: begin
                    if (w_gain_sts.done) begin
                        r_done_l <= 1'b0;
                        r_done_r <= 1'b0;
                        r_state  <= T_LANE;
                    end
                end
                T_LANE: begin
                    // Both lanes must report before the pair is merged into one beat.
                    r_done_l <= r_done_l | w_done_l;
                    r_done_r <= r_done_r | w_done_r;
                    if ((r_done_l | w_done_l) && (r_done_r | w_done_r)) begin
                        r_state <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (w_load_out) begin
                        r_state <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_ch.valid     = r_out_valid;
    assign o_out_ch.left_out  = r_out_l;
    assign o_out_ch.right_out = r_out_r;

    `SBS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, !i_in_ch.ready)
    `SBS_ASSERT_NOW(a_lanes_in_step, i_clk, i_rst_n, w_done_l, w_done_r)
    `SBS_ASSERT_NOW(a_gain_done_in_gain, i_clk, i_rst_n, w_gain_sts.done, r_state == T_GAIN)
    `SBS_ASSERT_NOW(a_first_held, i_clk, i_rst_n, r_state == T_GAIN && !i_in_ch.ready,
                    r_first == $past(r_first) || $past(w_in_acc))
endmodule
